FILE: hdl/sns_pkg.sv
`timescale 1ns / 1ps

package sns_pkg;

    localparam int SIZE_BITS_DEF = 24;
    localparam int DIGIT_BITS    = 4;
    localparam int REM_W         = 4;
    localparam int PIDX_W        = 3;
    localparam int FLOOR_SIZE    = 4;
    localparam int SMOOTH_LIMIT  = 2;

    localparam logic [PIDX_W-1:0] FIRST_PRIME_IDX = 3'd0;
    localparam logic [PIDX_W-1:0] LAST_PRIME_IDX  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST_START,
        ST_TEST_WAIT,
        ST_DIST,
        ST_PICK
    } sns_state_t;

    typedef struct packed {
        logic              start;
        logic [PIDX_W-1:0] prime_sel;
    } sns_div_cmd_t;

    typedef struct packed {
        logic done;
        logic zero_rem;
    } sns_div_stat_t;

    function automatic logic [REM_W-1:0] prime_value(input logic [PIDX_W-1:0] idx);
        logic [REM_W-1:0] p;
        case (idx)
            3'd0:    p = 4'd11;
            3'd1:    p = 4'd7;
            3'd2:    p = 4'd5;
            3'd3:    p = 4'd3;
            3'd4:    p = 4'd2;
            default: p = 4'd2;
        endcase
        return p;
    endfunction

endpackage

FILE: hdl/nearest_smooth_size.sv
// Candidates are tested downward from the request first, then upward ones.
// One request at a time: the next request is taken only after the pick has been written
//   to the output register, later while a stalled output holds the previous result.
// A finished result waits in the output register while the next request is taken.
// Reset: asynchronous, active low; clears the sequencer and output valid.
`timescale 1ns / 1ps

module nearest_smooth_size #(
    parameter int SIZE_BITS = sns_pkg::SIZE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [SIZE_BITS-1:0] request_size,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [SIZE_BITS:0]   smooth_size
);
    import sns_pkg::*;

    localparam int W = SIZE_BITS + 1;

    sns_state_t        state_reg;
    sns_state_t        state_next;
    logic [W-1:0]      req_reg;
    logic [W-1:0]      req_next;
    logic [W-1:0]      cand_reg;
    logic [W-1:0]      cand_next;
    logic [W-1:0]      v_reg;
    logic [W-1:0]      v_next;
    logic [PIDX_W-1:0] pidx_reg;
    logic [PIDX_W-1:0] pidx_next;
    logic              down_reg;
    logic              down_next;
    logic [W-1:0]      lo_reg;
    logic [W-1:0]      lo_next;
    logic [W-1:0]      hi_reg;
    logic [W-1:0]      hi_next;
    logic [W-1:0]      dlo_reg;
    logic [W-1:0]      dlo_next;
    logic [W-1:0]      dhi_reg;
    logic [W-1:0]      dhi_next;
    logic              below_reg;
    logic              below_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [W-1:0]      smooth_size_reg;
    logic [W-1:0]      smooth_size_next;

    sns_div_cmd_t  div_cmd;
    sns_div_stat_t div_stat;
    logic [W-1:0]  div_quot;
    logic [W-1:0]  cand_dec;
    logic [W-1:0]  cand_inc;
    logic          is_smooth;

    sns_div #(
        .W (W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .dividend (v_reg),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    assign cand_dec  = cand_reg - 1'b1;
    assign cand_inc  = cand_reg + 1'b1;
    assign is_smooth = (v_reg < W'(SMOOTH_LIMIT));

    always_comb
    begin
        state_next        = state_reg;
        req_next          = req_reg;
        cand_next         = cand_reg;
        v_next            = v_reg;
        pidx_next         = pidx_reg;
        down_next         = down_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        dlo_next          = dlo_reg;
        dhi_next          = dhi_reg;
        below_next        = below_reg;
        smooth_size_next  = smooth_size_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        in_ready          = 1'b0;
        div_cmd.start     = 1'b0;
        div_cmd.prime_sel = pidx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (request_size == '0)
                    begin
                        req_next = W'(1);
                    end
                    else
                    begin
                        req_next = {1'b0, request_size};
                    end
                    cand_next  = req_next;
                    v_next     = req_next;
                    pidx_next  = FIRST_PRIME_IDX;
                    down_next  = 1'b1;
                    state_next = ST_TEST_START;
                end
            end

            ST_TEST_START:
            begin
                div_cmd.start = 1'b1;
                state_next    = ST_TEST_WAIT;
            end

            ST_TEST_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_TEST_START;
                    if (div_stat.zero_rem)
                    begin
                        v_next = div_quot;
                    end
                    else if (pidx_reg != LAST_PRIME_IDX)
                    begin
                        pidx_next = pidx_reg + 1'b1;
                    end
                    else
                    begin
                        pidx_next = FIRST_PRIME_IDX;
                        if (down_reg)
                        begin
                            if (is_smooth || cand_dec < W'(FLOOR_SIZE))
                            begin
                                // switch to the upward search from the request
                                lo_next   = is_smooth ? cand_reg : W'(FLOOR_SIZE);
                                cand_next = req_reg;
                                v_next    = req_reg;
                                down_next = 1'b0;
                            end
                            else
                            begin
                                cand_next = cand_dec;
                                v_next    = cand_dec;
                            end
                        end
                        else if (is_smooth)
                        begin
                            hi_next    = cand_reg;
                            state_next = ST_DIST;
                        end
                        else
                        begin
                            cand_next = cand_inc;
                            v_next    = cand_inc;
                        end
                    end
                end
            end

            ST_DIST:
            begin
                below_next = (req_reg < lo_reg);
                dlo_next   = req_reg - lo_reg;
                dhi_next   = hi_reg - req_reg;
                state_next = ST_PICK;
            end

            ST_PICK:
            begin
                // hold until the output register is free; ties go upward
                if (!out_valid_reg || out_ready)
                begin
                    smooth_size_next = (below_reg || dlo_reg < dhi_reg) ? lo_reg : hi_reg;
                    out_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            pidx_reg      <= FIRST_PRIME_IDX;
            down_reg      <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pidx_reg      <= pidx_next;
            down_reg      <= down_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        cand_reg        <= cand_next;
        v_reg           <= v_next;
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        dlo_reg         <= dlo_next;
        dhi_reg         <= dhi_next;
        below_reg       <= below_next;
        smooth_size_reg <= smooth_size_next;
    end

    assign out_valid   = out_valid_reg;
    assign smooth_size = smooth_size_reg;

endmodule

FILE: hdl/sns_div.sv
`timescale 1ns / 1ps

module sns_div #(
    parameter int W = sns_pkg::SIZE_BITS_DEF + 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sns_pkg::sns_div_cmd_t  cmd,
    input  logic [W-1:0]         dividend,
    output sns_pkg::sns_div_stat_t stat,
    output logic [W-1:0]         quotient
);
    import sns_pkg::*;

    localparam int NSTEP = (W + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int DW    = NSTEP * DIGIT_BITS;
    localparam int CNT_W = $clog2(NSTEP + 1);

    logic [DW-1:0]         work_reg;
    logic [DW-1:0]         work_next;
    logic [REM_W-1:0]      rem_reg;
    logic [REM_W-1:0]      rem_next;
    logic [REM_W-1:0]      prime_reg;
    logic [REM_W-1:0]      prime_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic                  busy_reg;
    logic                  busy_next;
    logic [DW-1:0]         work_step;
    logic [REM_W-1:0]      rem_step;
    logic [REM_W:0]        trial;
    logic [DIGIT_BITS-1:0] qbits;

    // radix-16 long division by a small prime, one restoring step per bit
    always_comb
    begin
        rem_step = rem_reg;
        qbits    = '0;
        trial    = '0;
        for (int i = 0; i < DIGIT_BITS; i++)
        begin
            trial = {rem_step, work_reg[DW-1-i]};
            if (trial >= {1'b0, prime_reg})
            begin
                trial                  = trial - {1'b0, prime_reg};
                qbits[DIGIT_BITS-1-i] = 1'b1;
            end
            rem_step = trial[REM_W-1:0];
        end
        work_step = {work_reg[DW-DIGIT_BITS-1:0], qbits};
    end

    always_comb
    begin
        work_next  = work_reg;
        rem_next   = rem_reg;
        prime_next = prime_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        if (cmd.start)
        begin
            work_next  = DW'(dividend);
            rem_next   = '0;
            prime_next = prime_value(cmd.prime_sel);
            cnt_next   = CNT_W'(NSTEP);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            work_next = work_step;
            rem_next  = rem_step;
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg  <= work_next;
        rem_reg   <= rem_next;
        prime_reg <= prime_next;
    end

    assign stat.done     = busy_reg && (cnt_reg == CNT_W'(1));
    assign stat.zero_rem = (rem_step == '0);
    assign quotient      = work_step[W-1:0];

endmodule
